/* rtl/lpht_pkg.sv */
// Shared types, codes and widths of the linear-probing hash table.
package lpht_pkg;

    // Default slot count of the table
    localparam int SLOTS_DEFAULT = 16;

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Stream widths: key and value in, read value and entry count out
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISSING  = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO_KEY = 2'd3
    } status_t;

    // One slot of the table memory
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage

/* rtl/linear_probe_hash_table_top.sv */
// Sequence: put, get and remove register the input, probe k slots and register the result,
// k in 1..SLOTS; a slot count that is not a power of two adds a step of key reduction.
// A zero key goes straight to the result; a clear zeroes every row (one memory row a cycle).
// Throughput: one item at a time, the next accepted the cycle after the result is registered;
// the probe is paced by the single-port read of the slot memory, one slot per cycle.
// Reset: aresetn low clears the control state; a clearing pass over every slot follows.
module linear_probe_hash_table_top #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: key [31:0], value [63:32]
    input  logic [lpht_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation [1:0]
    input  logic [lpht_pkg::OP_W-1:0]      s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: read_value [31:0], entry_count [36:32], zero fill [39:37]
    output logic [lpht_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: status [1:0]
    output logic [lpht_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import lpht_pkg::*;

    localparam int  IdxW      = $clog2(SLOTS);
    localparam int  CntW      = $clog2(SLOTS + 1);
    localparam bit  SlotsPow2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int  ShiftQ    = KEY_W - 1 + IdxW;
    localparam logic [KEY_W-1:0] RecipM = KEY_W'((64'd1 << ShiftQ) / SLOTS);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [IdxW-1:0]      sweep_idx_reg;
    logic                 clear_pending_reg;
    logic [CntW-1:0]      cnt_reg;
    logic [IdxW-1:0]      probe_idx_reg;
    logic [IdxW-1:0]      n_reg;
    logic [IdxW:0]        quot_low_reg;
    op_t                  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   val_reg;
    status_t              res_status_reg;
    logic [VALUE_W-1:0]   res_value_reg;
    logic                 m_tvalid_reg;
    status_t              m_status_reg;
    logic [VALUE_W-1:0]   m_value_reg;
    logic [COUNT_W-1:0]   m_count_reg;

    // Slot memory
    slot_t                mem [SLOTS];
    slot_t                rd_data_reg;
    logic [IdxW-1:0]      rd_addr;
    logic                 wr_en;
    logic [IdxW-1:0]      wr_addr;
    slot_t                wr_data;

    logic [KEY_W-1:0]     in_key;
    logic [VALUE_W-1:0]   in_value;
    op_t                  in_op;
    logic [IdxW-1:0]      home_direct;
    logic [2*KEY_W-1:0]   hash_prod;
    logic [IdxW:0]        rem_raw;
    logic [IdxW:0]        rem_sel;
    logic [IdxW-1:0]      rem_next;
    logic [IdxW-1:0]      next_idx;
    logic                 hit;
    logic                 free;
    logic                 last_probe;
    logic [CntW+COUNT_W-1:0] cnt_ext;

    assign in_key      = s_tdata[KEY_W-1:0];
    assign in_value    = s_tdata[KEY_W+VALUE_W-1:KEY_W];
    assign in_op       = op_t'(s_tuser);
    assign home_direct = in_key[IdxW-1:0];

    // Reduce the key modulo the slot count: reciprocal estimate, one correcting subtract
    assign hash_prod = in_key * RecipM;
    assign rem_raw   = key_reg[IdxW:0] - quot_low_reg * (IdxW+1)'(SLOTS);
    assign rem_sel   = (rem_raw >= (IdxW+1)'(SLOTS)) ? rem_raw - (IdxW+1)'(SLOTS)
                                                     : rem_raw;
    assign rem_next  = rem_sel[IdxW-1:0];

    // Probe decisions on the slot read last cycle
    assign next_idx   = (probe_idx_reg == IdxW'(SLOTS - 1)) ? '0 : probe_idx_reg + 1'b1;
    assign hit        = rd_data_reg.used && (rd_data_reg.key == key_reg);
    assign free       = !rd_data_reg.used;
    assign last_probe = (n_reg == IdxW'(SLOTS - 1));

    assign cnt_ext = {{COUNT_W{1'b0}}, cnt_reg};

    // Select read address: home slot on entry, the slot after the current one while probing, else the current slot
    always_comb begin
        unique case (state_reg)
            S_IDLE:  rd_addr = home_direct;
            S_HASH:  rd_addr = rem_next;
            S_PROBE: rd_addr = next_idx;
            default: rd_addr = probe_idx_reg;
        endcase
    end

    // Write back on a put or remove, zero rows during a clearing pass
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = probe_idx_reg;
        wr_data = '0;
        if (state_reg == S_SWEEP) begin
            wr_en   = 1'b1;
            wr_addr = sweep_idx_reg;
        end else if (state_reg == S_PROBE) begin
            if (op_reg == OP_PUT && (hit || free)) begin
                wr_en   = 1'b1;
                wr_data = '{used: 1'b1, key: key_reg, value: val_reg};
            end else if (op_reg == OP_REMOVE && hit) begin
                wr_en = 1'b1;
            end
        end
    end

    // Slot memory, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign s_tready = (state_reg == S_IDLE);

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_SWEEP;
            sweep_idx_reg     <= '0;
            clear_pending_reg <= 1'b0;
            cnt_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SWEEP: begin
                    if (sweep_idx_reg == IdxW'(SLOTS - 1)) begin
                        sweep_idx_reg     <= '0;
                        clear_pending_reg <= 1'b0;
                        state_reg         <= clear_pending_reg ? S_DONE : S_IDLE;
                    end else begin
                        sweep_idx_reg <= sweep_idx_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg        <= in_op;
                        key_reg       <= in_key;
                        val_reg       <= in_value;
                        res_status_reg <= (in_op != OP_CLEAR && in_key == '0) ? ST_ZERO_KEY
                                                                              : ST_OK;
                        res_value_reg  <= '0;
                        if (in_op == OP_CLEAR) begin
                            cnt_reg           <= '0;
                            clear_pending_reg <= 1'b1;
                            sweep_idx_reg     <= '0;
                            state_reg         <= S_SWEEP;
                        end else if (in_key == '0) begin
                            state_reg      <= S_DONE;
                        end else if (SlotsPow2) begin
                            probe_idx_reg <= home_direct;
                            n_reg         <= '0;
                            state_reg     <= S_PROBE;
                        end else begin
                            quot_low_reg <= hash_prod[ShiftQ +: (IdxW+1)];
                            state_reg    <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    probe_idx_reg <= rem_next;
                    n_reg         <= '0;
                    state_reg     <= S_PROBE;
                end
                S_PROBE: begin
                    if (hit) begin
                        res_status_reg <= ST_OK;
                        if (op_reg == OP_GET) begin
                            res_value_reg <= rd_data_reg.value;
                        end else if (op_reg == OP_REMOVE) begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                        state_reg <= S_DONE;
                    end else if (free) begin
                        if (op_reg == OP_PUT) begin
                            res_status_reg <= ST_OK;
                            cnt_reg        <= cnt_reg + 1'b1;
                        end else begin
                            res_status_reg <= ST_MISSING;
                        end
                        state_reg <= S_DONE;
                    end else if (last_probe) begin
                        res_status_reg <= (op_reg == OP_PUT) ? ST_FULL : ST_MISSING;
                        state_reg      <= S_DONE;
                    end else begin
                        probe_idx_reg <= next_idx;
                        n_reg         <= n_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_value_reg  <= res_value_reg;
                        m_count_reg  <= cnt_ext[COUNT_W-1:0];
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, m_count_reg, m_value_reg};

`ifndef NO_ASSERTIONS
    // A full lap without match or free slot only happens with every slot used
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE && !hit && !free && last_probe) |-> (cnt_reg == CntW'(SLOTS)))
        else $error("probe lapped a table that is not full");

    // A successful remove lowers the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE && hit && op_reg == OP_REMOVE)
        |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("remove did not lower the entry count");

    // A result is only raised from the completion state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");
`endif

endmodule
